[src/assert_macros.svh]
// Assertion macros shared by the stack machine executor RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define SME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SME_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sme_pkg.sv]
// Shared types and codes for the stack machine executor.
// No dependencies; imported by sme_div and the top level.
`timescale 1ns / 1ps

package sme_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 3;
    localparam int DEPTH_W = 7;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_HALT = 3'd0,
        OP_PUSH = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_OUT  = 3'd6
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE   = 2'd0,
        KIND_OUTPUT = 2'd1,
        KIND_HALTED = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_UNDERFLOW = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_DIVZERO   = 3'd3,
        ERR_UNKNOWN   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[src/sme_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[src/sme_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on sme_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sme_div
    import sme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  word_t     num,
    input  word_t     den,
    output word_t     quotient,
    output div_stat_t stat
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    word_t             rem_reg;
    word_t             quo_reg;
    word_t             den_reg;
    logic              neg_reg;

    logic              num_neg;
    logic              den_neg;
    word_t             num_mag;
    word_t             den_mag;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;

    assign num_neg   = num[WORD_W-1];
    assign den_neg   = den[WORD_W-1];
    assign num_mag   = num_neg ? (~num + word_t'(1)) : num;
    assign den_mag   = den_neg ? (~den + word_t'(1)) : den;
    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(WORD_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: restoring division on magnitudes; the remainder stays below
    // the divisor magnitude, so it fits one word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num_mag;
            den_reg <= den_mag;
            neg_reg <= num_neg ^ den_neg;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_reg <= diff[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = neg_reg ? (~quo_reg + word_t'(1)) : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `SME_ASSERT(a_div_no_restart, start |-> !busy_reg, "divider started while busy")
    `SME_ASSERT(a_div_done_follows, $fell(busy_reg) |-> done_reg, "divider finished without done")
    `SME_ASSERT(a_div_excl, !(busy_reg && done_reg), "divider busy and done together")

endmodule

[src/stack_machine_executor_unit.sv]
// Stack machine executor top level: sequencer, arithmetic and result register.
// Depends on sme_pkg, sme_ram, sme_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  in      | in_valid / in_stall   | op, operand
//  out     | out_valid / out_stall | kind, value, error_code, depth
//
// An instruction is accepted in IDLE, while the RAM reads the two top stack
// entries, and is computed and written back in EXEC once the output register
// is free. Div moves on to DIV: the iterative divider resolves one quotient
// bit per cycle, and the write-back follows once it reports done and the output register is free.
// Reset clears the stack count, the stop flag, the sequencer and the output
// valid; stack RAM contents are never cleared (count bounds every read).
// A stalled result holds in the output register; the next beat is still
// accepted, and only its write-back waits for that register to drain.

module stack_machine_executor_unit
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [OP_W-1:0]           op,
    input  logic signed [WORD_W-1:0]  operand,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [KIND_W-1:0]         kind,
    output logic signed [WORD_W-1:0]  value,
    output logic [ERR_W-1:0]          error_code,
    output logic [DEPTH_W-1:0]        depth
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    // Sequencer and architectural state
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   depth_reg;
    logic               stopped_reg;

    // Captured instruction beat
    logic [OP_W-1:0]    op_reg;
    word_t              operand_reg;

    // Output register
    logic               out_valid_reg;
    kind_t              kind_reg;
    word_t              value_reg;
    err_t               err_reg;
    logic [DEPTH_W-1:0] depth_out_reg;

    // Stack RAM ports
    logic [CNT_W-1:0]   depth_m1;
    logic [CNT_W-1:0]   depth_m2;
    logic [AW-1:0]      addr_top;
    logic [AW-1:0]      addr_sec;
    word_t              rd_top;
    word_t              rd_sec;
    logic               ram_we;

    // Decoded outcome of the current instruction
    kind_t              c_kind;
    err_t               c_err;
    word_t              c_value;
    logic [CNT_W-1:0]   c_depth;
    logic               c_stop;
    logic               c_wr;
    logic [AW-1:0]      c_waddr;
    word_t              c_wdata;
    logic               c_div;

    logic               out_free;
    logic               commit;
    logic               div_start;
    word_t              quotient;
    div_stat_t          div_stat;
    word_t              product;
    logic [EXT_W-1:0]   depth_ext;

    assign depth_m1 = depth_reg - CNT_W'(1);
    assign depth_m2 = depth_reg - CNT_W'(2);
    assign addr_top = depth_m1[AW-1:0];
    assign addr_sec = depth_m2[AW-1:0];
    assign product  = rd_sec * rd_top;

    // Read the two top entries every cycle; the count only moves on commit,
    // so the data is fresh by the EXEC cycle of the next beat.
    sme_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (c_waddr),
        .wdata   (c_wdata),
        .raddr_a (addr_top),
        .raddr_b (addr_sec),
        .rdata_a (rd_top),
        .rdata_b (rd_sec)
    );

    sme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (rd_sec),
        .den      (rd_top),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Decode the captured beat against the current stack
    always_comb
    begin
        c_kind  = KIND_DONE;
        c_err   = ERR_NONE;
        c_value = '0;
        c_depth = depth_reg;
        c_stop  = 1'b0;
        c_wr    = 1'b0;
        c_waddr = addr_sec;
        c_wdata = operand_reg;
        c_div   = 1'b0;
        if (state_reg == ST_DIV)
        begin
            // Divider result goes back in place of the second entry
            c_wr    = 1'b1;
            c_wdata = quotient;
            c_depth = depth_m1;
        end
        else if (stopped_reg)
        begin
            c_kind = KIND_HALTED;
        end
        else
        begin
            case (op_t'(op_reg))
                OP_HALT:
                begin
                    c_kind = KIND_HALTED;
                    c_stop = 1'b1;
                end
                OP_PUSH:
                begin
                    if (depth_reg == CNT_W'(STACK_DEPTH))
                    begin
                        c_kind = KIND_ERROR;
                        c_err  = ERR_OVERFLOW;
                        c_stop = 1'b1;
                    end
                    else
                    begin
                        c_wr    = 1'b1;
                        c_waddr = depth_reg[AW-1:0];
                        c_depth = depth_reg + CNT_W'(1);
                    end
                end
                OP_OUT:
                begin
                    if (depth_reg == '0)
                    begin
                        c_kind = KIND_ERROR;
                        c_err  = ERR_UNDERFLOW;
                        c_stop = 1'b1;
                    end
                    else
                    begin
                        c_kind  = KIND_OUTPUT;
                        c_value = rd_top;
                        c_depth = depth_m1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    if (depth_reg < CNT_W'(2))
                    begin
                        c_kind = KIND_ERROR;
                        c_err  = ERR_UNDERFLOW;
                        c_stop = 1'b1;
                    end
                    else if (op_t'(op_reg) == OP_DIV)
                    begin
                        if (rd_top == '0)
                        begin
                            c_kind = KIND_ERROR;
                            c_err  = ERR_DIVZERO;
                            c_stop = 1'b1;
                        end
                        else
                        begin
                            c_div = 1'b1;
                        end
                    end
                    else
                    begin
                        c_wr    = 1'b1;
                        c_depth = depth_m1;
                        case (op_t'(op_reg))
                            OP_ADD:  c_wdata = rd_sec + rd_top;
                            OP_SUB:  c_wdata = rd_sec - rd_top;
                            default: c_wdata = product;
                        endcase
                    end
                end
                default:
                begin
                    c_kind = KIND_ERROR;
                    c_err  = ERR_UNKNOWN;
                    c_stop = 1'b1;
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (c_div)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done && out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_we   = commit && c_wr;
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                depth_reg     <= c_depth;
                stopped_reg   <= stopped_reg || c_stop;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                // Drop the result once the beat is taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign depth_ext = EXT_W'(c_depth);

    // Hold the beat and the result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg      <= op;
            operand_reg <= operand;
        end
        if (commit)
        begin
            kind_reg      <= c_kind;
            value_reg     <= c_value;
            err_reg       <= c_err;
            depth_out_reg <= depth_ext[DEPTH_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign value      = value_reg;
    assign error_code = err_reg;
    assign depth      = depth_out_reg;

    `SME_ASSERT(a_stop_sticky, stopped_reg |=> stopped_reg, "stop flag cleared")
    `SME_ASSERT(a_no_write_stopped, stopped_reg |-> !ram_we, "stack written after stop")
    `SME_ASSERT(a_depth_bound, depth_reg <= CNT_W'(STACK_DEPTH), "stack count past depth")
    `SME_ASSERT(a_div_busy_in_div, div_stat.busy |-> (state_reg == ST_DIV), "divider busy outside divide")
    `SME_ASSERT(a_depth_step, 1'b1 |=> (depth_reg == $past(depth_reg) || depth_reg == $past(depth_reg) + CNT_W'(1) || depth_reg == $past(depth_reg) - CNT_W'(1)), "stack count jumped")

endmodule
